### hw/rtl/nlp_pkg.sv
`default_nettype none

package nlp_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'd39;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_MINUS  = 8'd45;
    localparam logic [7:0] CH_ZERO   = 8'd48;
    localparam logic [7:0] CH_X      = 8'd120;
    localparam logic [7:0] CH_N      = 8'd110;
    localparam logic [7:0] CH_T      = 8'd116;
    localparam logic [7:0] HEX_SPLIT = 8'd58;

    // digit offsets
    localparam logic [31:0] DIGIT_BASE     = 32'd48;
    localparam logic [31:0] HEX_ALPHA_BASE = 32'd87;

    // escape results
    localparam logic [31:0] ESC_NUL   = 32'd0;
    localparam logic [31:0] ESC_LF    = 32'd10;
    localparam logic [31:0] ESC_TAB   = 32'd9;
    localparam logic [31:0] ESC_SLASH = 32'd92;
    localparam logic [31:0] ESC_QUOTE = 32'd39;

    localparam int          HEAD_DEPTH = 3;
    localparam logic [1:0]  POS_SAT    = 2'd3;

    typedef struct packed {
        logic [1:0]                  pos;
        logic [HEAD_DEPTH-1:0][7:0]  head;
        logic [31:0]                 dec_acc;
        logic [31:0]                 hex_acc;
        logic                        neg;
    } nlp_state_t;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

endpackage

`default_nettype wire

### hw/rtl/nlp_step.sv
`default_nettype none

// Per-byte token state update: head capture, sign, decimal and hex accumulators.
module nlp_step
    import nlp_pkg::*;
(
    input  nlp_state_t  cur,
    input  logic [7:0]  ch,
    output nlp_state_t  nxt
);

    logic [31:0] sx;
    logic        below;
    logic [31:0] hex_sub;

    always_comb
    begin
        sx      = sext8(ch);
        below   = (ch < HEX_SPLIT) || ch[7];
        hex_sub = below ? DIGIT_BASE : HEX_ALPHA_BASE;
        nxt     = cur;

        for (int i = 0; i < HEAD_DEPTH; i++)
        begin
            if (cur.pos == 2'(i))
            begin
                nxt.head[i] = ch;
            end
        end

        if ((cur.pos == 2'd0) && (ch == CH_MINUS))
        begin
            nxt.neg = 1'b1;
        end
        else
        begin
            // acc * 10 = acc * 8 + acc * 2
            nxt.dec_acc = {cur.dec_acc[28:0], 3'b000} + {cur.dec_acc[30:0], 1'b0}
                          + sx - DIGIT_BASE;
        end

        if (cur.pos >= 2'd2)
        begin
            nxt.hex_acc = {cur.hex_acc[27:0], 4'b0000} + sx - hex_sub;
        end

        if (cur.pos != POS_SAT)
        begin
            nxt.pos = cur.pos + 2'd1;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/nlp_classify.sv
`default_nettype none

// Picks the token's value and error flag from the updated state on its final byte.
module nlp_classify
    import nlp_pkg::*;
(
    input  nlp_state_t   st,
    input  logic [1:0]   idx,
    input  logic [7:0]   ch,
    output logic [31:0]  value,
    output logic         error
);

    logic [7:0]  third;
    logic [31:0] esc_val;

    always_comb
    begin
        third = (idx >= 2'd2) ? st.head[2] : 8'd0;
        unique case (third)
            CH_ZERO:   esc_val = ESC_NUL;
            CH_N:      esc_val = ESC_LF;
            CH_T:      esc_val = ESC_TAB;
            CH_BSLASH: esc_val = ESC_SLASH;
            CH_QUOTE:  esc_val = ESC_QUOTE;
            default:   esc_val = ESC_SLASH;
        endcase
    end

    always_comb
    begin
        value = '0;
        error = 1'b0;
        priority if ((st.head[0] == CH_QUOTE) && (ch == CH_QUOTE))
        begin
            if (idx == 2'd0)
                value = '0;
            else if (st.head[1] == CH_BSLASH)
                value = esc_val;
            else
                value = sext8(st.head[1]);
        end
        else if ((idx != 2'd0) && (st.head[0] == CH_ZERO) && (st.head[1] == CH_X))
        begin
            // bare prefix flags an error
            if (idx == 2'd1)
                error = 1'b1;
            else
                value = st.hex_acc;
        end
        else if ((idx == 2'd0) && st.neg)
        begin
            error = 1'b1;
        end
        else
        begin
            value = st.neg ? (32'd0 - st.dec_acc) : st.dec_acc;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/numeric_literal_parser_unit.sv
// Result path: a token's last byte is registered in the input register, and its result
// is then registered in the output register, which raises out_valid.
// Throughput: one byte per cycle while in_stall is low; the token state updates in a single pass.
// in_stall rises only while a finished result waits in the output register
// under out_stall and the next last byte is already held.
// Reset (rst_n low, async): clears valids and the token state.
`default_nettype none

module numeric_literal_parser_unit
    import nlp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // byte input
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [7:0]         ch,
    input  wire logic               last,
    // result output
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      value,
    output logic                    error
);

    // input register
    logic        in_valid_reg;
    logic [7:0]  ch_reg;
    logic        last_reg;

    // token state, cleared after each final byte
    nlp_state_t  state_reg;
    nlp_state_t  state_next;
    nlp_state_t  stepped;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] value_reg;
    logic        error_reg;

    logic [31:0] res_value;
    logic        res_error;
    logic        advance;

    // A held byte moves on unless it ends a token and the output slot is blocked.
    assign advance  = in_valid_reg && (!last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    nlp_step u_step (
        .cur (state_reg),
        .ch  (ch_reg),
        .nxt (stepped)
    );

    nlp_classify u_classify (
        .st    (stepped),
        .idx   (state_reg.pos),
        .ch    (ch_reg),
        .value (res_value),
        .error (res_error)
    );

    always_comb
    begin
        state_next = state_reg;
        if (advance)
        begin
            state_next = last_reg ? '0 : stepped;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && last_reg)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg   <= ch;
            last_reg <= last;
        end
        if (advance && last_reg)
        begin
            value_reg <= res_value;
            error_reg <= res_error;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign error     = error_reg;

endmodule

`default_nettype wire

### hw/rtl/nlp_checker.sv
`default_nettype none

module nlp_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               last,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic signed [31:0] value,
    input wire logic               error
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> value == 32'sd0)
        else $error("error result with nonzero value");

    // backpressure only comes from a blocked output
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with output free");

    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
        else $error("result without a final byte");

endmodule

bind numeric_literal_parser_unit nlp_checker u_nlp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .error     (error)
);

`default_nettype wire
